[rtl/core/lcdnib_pkg.sv]
package lcdnib_pkg;

    typedef enum logic [1:0] {
        CMD_INSTR  = 2'd0,
        CMD_CHAR   = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_INIT   = 2'd3
    } lcd_cmd_t;

    localparam int IDX_W = 5;
    localparam int WAIT_W = 13;
    localparam int ADDR_W = 7;

    // configuration register indexes
    localparam logic [1:0] REG_EXP_ADDR  = 2'd0;
    localparam logic [1:0] REG_BACKLIGHT = 2'd1;

    localparam logic [ADDR_W-1:0] EXP_ADDR_RESET = 7'd39;
    localparam logic              BACKLIGHT_RESET = 1'b1;

    // expander pin bits
    localparam int BIT_RS = 0;
    localparam int BIT_E  = 2;
    localparam int BIT_BL = 3;

    localparam logic [IDX_W-1:0] LAST_IDX_BYTE4 = 5'd3;
    localparam logic [IDX_W-1:0] LAST_IDX_INIT  = 5'd23;
    localparam logic [IDX_W-1:0] INIT_NIB_END   = 5'd8;

    localparam logic [WAIT_W-1:0] WAIT_BYTE      = 13'd50;
    localparam logic [WAIT_W-1:0] WAIT_INIT_LONG = 13'd5050;
    localparam logic [WAIT_W-1:0] WAIT_INIT_MID  = 13'd250;
    localparam logic [WAIT_W-1:0] WAIT_CLEAR     = 13'd2050;

    localparam logic [7:0] DDRAM_SET = 8'h80;

    // instructions following the nibble-mode reset writes
    function automatic logic [7:0] init_instr(input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0: r = 8'h28;
            2'd1: r = 8'h0C;
            2'd2: r = 8'h06;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/char_lcd_nibble_sequencer.sv]
// a taken request is held in the request registers, and each byte in the output registers
// throughput: one byte per cycle while active; 4 bytes per instruction, character or
// cursor set, 24 per initialize; busy drops on a request's last byte so the next follows
// without a gap. results are strobed for one cycle and the receiver cannot stall
// reset: async active low; clears the sequencer and loads address 39, backlight on
module char_lcd_nibble_sequencer
    import lcdnib_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [7:0]          value,
    input  logic [1:0]          row,
    input  logic [4:0]          col,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data,
    output logic                result_valid,
    output logic [7:0]          expander_byte,
    output logic [ADDR_W-1:0]   target_address,
    output logic [WAIT_W-1:0]   wait_after_us,
    output logic                last
);

    logic [ADDR_W-1:0] exp_addr_reg;
    logic              backlight_reg;

    logic              active_reg, active_next;
    lcd_cmd_t          cmd_reg, cmd_next;
    logic [7:0]        data_reg, data_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              out_valid_reg;
    logic [7:0]        byte_reg, byte_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              last_reg;

    logic              cur_last;
    logic              accept;
    logic [7:0]        cursor_addr;
    logic [7:0]        wr_byte;
    logic [3:0]        nib;
    logic              rs;
    logic              bl;
    logic              e_bit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_addr_reg  <= EXP_ADDR_RESET;
            backlight_reg <= BACKLIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXP_ADDR:  exp_addr_reg  <= cfg_data;
                REG_BACKLIGHT: backlight_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cur_last = active_reg &&
                      (idx_reg == ((cmd_reg == CMD_INIT) ? LAST_IDX_INIT : LAST_IDX_BYTE4));
    assign busy     = active_reg && !cur_last;
    assign accept   = start && !busy;

    // row bit 0 adds 64, row bit 1 adds 20
    assign cursor_addr = DDRAM_SET + {1'b0, row[0], 6'd0} + (row[1] ? 8'd20 : 8'd0)
                         + {3'd0, col};

    always_comb
    begin
        active_next = active_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        if (accept)
        begin
            active_next = 1'b1;
            cmd_next    = lcd_cmd_t'(command);
            data_next   = (lcd_cmd_t'(command) == CMD_CURSOR) ? cursor_addr : value;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (cur_last)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    // one expander byte from the current request and its byte index
    always_comb
    begin
        wr_byte   = data_reg;
        rs        = 1'b0;
        bl        = backlight_reg;
        e_bit     = !idx_reg[0];
        wait_next = WAIT_BYTE;
        case (cmd_reg)
            CMD_CHAR: rs = 1'b1;
            CMD_INIT:
            begin
                if (idx_reg < INIT_NIB_END)
                begin
                    wr_byte = (idx_reg[2:1] == 2'd3) ? 8'h20 : 8'h30;
                    bl      = 1'b0;
                    if (idx_reg == 5'd1)
                        wait_next = WAIT_INIT_LONG;
                    else if (idx_reg == 5'd3)
                        wait_next = WAIT_INIT_MID;
                end
                else
                begin
                    wr_byte = init_instr(2'(idx_reg[4:2] - 3'd2));
                    if (idx_reg == LAST_IDX_INIT)
                        wait_next = WAIT_CLEAR;
                end
            end
            default: ;
        endcase
        // the reset nibbles send only the high half
        if (cmd_reg == CMD_INIT && idx_reg < INIT_NIB_END)
            nib = wr_byte[7:4];
        else
            nib = idx_reg[1] ? wr_byte[3:0] : wr_byte[7:4];
        byte_next         = {nib, 4'd0};
        byte_next[BIT_RS] = rs;
        byte_next[BIT_E]  = e_bit;
        byte_next[BIT_BL] = bl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        data_reg <= data_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        addr_reg <= exp_addr_reg;
        wait_reg <= wait_next;
        last_reg <= cur_last;
    end

    assign result_valid   = out_valid_reg;
    assign expander_byte  = byte_reg;
    assign target_address = addr_reg;
    assign wait_after_us  = wait_reg;
    assign last           = last_reg;

    // a taken request always produces a byte once it has passed the request and output registers
    a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 result_valid)
        else $error("no result after accepted request");

    // while busy another byte must follow
    a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid && !last)
        else $error("busy without pending byte");

    // the final init byte carries the clear-display wait
    a_init_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && cmd_reg == CMD_INIT && cur_last) |=>
            (last && wait_after_us == WAIT_CLEAR))
        else $error("init tail wait wrong");

    // a result with last set ends the request, so busy was low in the previous cycle
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> $past(!busy))
        else $error("last byte while still busy");

endmodule

[test/char_lcd_nibble_checker.sv]
`timescale 1ns / 100ps

module char_lcd_nibble_checker
    import lcdnib_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        command,
    input  logic [7:0]        value,
    input  logic [1:0]        row,
    input  logic [4:0]        col,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              result_valid,
    input  logic [7:0]        expander_byte,
    input  logic [ADDR_W-1:0] target_address,
    input  logic [WAIT_W-1:0] wait_after_us,
    input  logic              last,
    output int                mismatches,
    output int                bytes_pending
);

    localparam logic [7:0] E_MASK = 8'(1 << BIT_E);

    typedef struct packed {
        logic [7:0]        pins;
        logic [ADDR_W-1:0] dest;
        logic [WAIT_W-1:0] delay_us;
        logic              last;
    } lcd_byte_t;

    lcd_byte_t         expected_bytes[$];
    logic [ADDR_W-1:0] exp_address;
    logic              backlight;

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    function automatic void queue_byte(input logic [7:0] pins, input logic [WAIT_W-1:0] delay_us);
        lcd_byte_t b;
        b.pins = pins;
        b.dest = exp_address;
        b.delay_us = delay_us;
        b.last = 1'b0;
        expected_bytes.push_back(b);
    endfunction

    // one 8-bit write as two nibbles, each strobed with E high then low
    function automatic void queue_nibble_write(input logic [7:0] v, input logic rs);
        logic [7:0] flags;
        logic [7:0] hi;
        logic [7:0] lo;
        flags = 8'h00;
        flags[BIT_RS] = rs;
        flags[BIT_BL] = backlight;
        hi = {v[7:4], 4'h0} | flags;
        lo = {v[3:0], 4'h0} | flags;
        queue_byte(hi | E_MASK, WAIT_BYTE);
        queue_byte(hi, WAIT_BYTE);
        queue_byte(lo | E_MASK, WAIT_BYTE);
        queue_byte(lo, WAIT_BYTE);
    endfunction

    function automatic void predict_request(input lcd_cmd_t cmd, input logic [7:0] val,
                                            input logic [1:0] r, input logic [4:0] c);
        logic [7:0] ddram;
        lcd_byte_t  tail;
        case (cmd)
            CMD_INSTR: queue_nibble_write(val, 1'b0);
            CMD_CHAR: queue_nibble_write(val, 1'b1);
            CMD_CURSOR:
            begin
                ddram = DDRAM_SET + (r[0] ? 8'd64 : 8'd0) + (r[1] ? 8'd20 : 8'd0) + 8'(c);
                queue_nibble_write(ddram, 1'b0);
            end
            default:
            begin
                // wake-up nibbles go out with RS low and backlight off regardless of setting
                queue_byte(8'h30 | E_MASK, WAIT_BYTE);
                queue_byte(8'h30, WAIT_INIT_LONG);
                queue_byte(8'h30 | E_MASK, WAIT_BYTE);
                queue_byte(8'h30, WAIT_INIT_MID);
                queue_byte(8'h30 | E_MASK, WAIT_BYTE);
                queue_byte(8'h30, WAIT_BYTE);
                queue_byte(8'h20 | E_MASK, WAIT_BYTE);
                queue_byte(8'h20, WAIT_BYTE);
                queue_nibble_write(8'h28, 1'b0);
                queue_nibble_write(8'h0C, 1'b0);
                queue_nibble_write(8'h06, 1'b0);
                queue_nibble_write(8'h01, 1'b0);
            end
        endcase
        tail = expected_bytes.pop_back();
        tail.last = 1'b1;
        if (cmd == CMD_INIT)
            tail.delay_us = WAIT_CLEAR;
        expected_bytes.push_back(tail);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lcd_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            exp_address = EXP_ADDR_RESET;
            backlight = BACKLIGHT_RESET;
            bytes_pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("byte %h with nothing pending", expander_byte));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (expander_byte !== want.pins)
                        report_mismatch($sformatf("expander_byte got %h want %h",
                                                  expander_byte, want.pins));
                    if (target_address !== want.dest)
                        report_mismatch($sformatf("target_address got %0d want %0d",
                                                  target_address, want.dest));
                    if (wait_after_us !== want.delay_us)
                        report_mismatch($sformatf("wait_after_us got %0d want %0d",
                                                  wait_after_us, want.delay_us));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %b want %b", last, want.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_EXP_ADDR: exp_address = cfg_data;
                    REG_BACKLIGHT: backlight = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_request(lcd_cmd_t'(command), value, row, col);
            bytes_pending <= expected_bytes.size();
        end
    end

endmodule

[test/char_lcd_nibble_sequencer_tb.sv]
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_tb;
    import lcdnib_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 4;
    localparam int PHASE_ITEMS = 120;
    // index past the last register, writes to it must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        command = CMD_INSTR;
    logic [7:0]        value = 8'h00;
    logic [1:0]        row = 2'd0;
    logic [4:0]        col = 5'd0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = REG_EXP_ADDR;
    logic [ADDR_W-1:0] cfg_data = '0;
    logic              result_valid;
    logic [7:0]        expander_byte;
    logic [ADDR_W-1:0] target_address;
    logic [WAIT_W-1:0] wait_after_us;
    logic              last;
    int                mismatches;
    int                bytes_pending;
    int                idle_pct = 0;
    int                cycles = 0;

    char_lcd_nibble_sequencer uut (.*);

    char_lcd_nibble_checker chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("char_lcd_nibble_sequencer test failed");
            $finish;
        end
    end

    // start stays high across back-to-back transfers unless a gap is drawn
    task automatic send_request(input lcd_cmd_t cmd, input logic [7:0] val,
                                input logic [1:0] r, input logic [4:0] c);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, ($urandom_range(9) == 0) ? 30 : 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        value <= val;
        row <= r;
        col <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic random_request();
        int pick;
        int c;
        lcd_cmd_t cmd;
        pick = $urandom_range(99);
        if (pick < 30)
            cmd = CMD_INSTR;
        else if (pick < 70)
            cmd = CMD_CHAR;
        else if (pick < 90)
            cmd = CMD_CURSOR;
        else
            cmd = CMD_INIT;
        c = ($urandom_range(7) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 19);
        send_request(cmd, 8'($urandom), 2'($urandom), 5'(c));
    endtask

    task automatic drain();
        do @(posedge clk); while (bytes_pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [ADDR_W-1:0] addr, input logic bl);
        write_reg(REG_EXP_ADDR, addr);
        // upper data bits are don't-care for the backlight register
        write_reg(REG_BACKLIGHT, {6'($urandom), bl});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at reset settings
        idle_pct = 30;
        send_request(CMD_INIT, 8'h00, 2'd0, 5'd0);
        send_request(CMD_INSTR, 8'h00, 2'd3, 5'd31);
        send_request(CMD_INSTR, 8'hFF, 2'd0, 5'd0);
        send_request(CMD_CHAR, 8'h00, 2'd0, 5'd0);
        send_request(CMD_CHAR, 8'hFF, 2'd3, 5'd31);
        send_request(CMD_CHAR, 8'hA5, 2'd1, 5'd7);
        send_request(CMD_CHAR, 8'h5A, 2'd2, 5'd12);
        send_request(CMD_CURSOR, 8'hFF, 2'd0, 5'd0);
        send_request(CMD_CURSOR, 8'h00, 2'd1, 5'd0);
        send_request(CMD_CURSOR, 8'h00, 2'd2, 5'd19);
        send_request(CMD_CURSOR, 8'h00, 2'd3, 5'd19);
        // columns past the line end just give a larger address
        send_request(CMD_CURSOR, 8'h00, 2'd3, 5'd31);
        send_request(CMD_CURSOR, 8'h00, 2'd0, 5'd20);
        send_request(CMD_INIT, 8'hFF, 2'd3, 5'd31);
        send_request(CMD_INSTR, 8'h01, 2'd0, 5'd0);
        start <= 1'b0;
        drain();
        write_reg(REG_SPARE, 7'($urandom));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    apply_settings(7'd0, 1'b0);
                    idle_pct = 0;
                end
                1:
                begin
                    apply_settings(7'h7F, 1'b1);
                    idle_pct = 54;
                end
                2:
                begin
                    apply_settings(7'($urandom), 1'b0);
                    idle_pct = 0;
                end
                default:
                begin
                    apply_settings(EXP_ADDR_RESET, 1'b1);
                    idle_pct = 38;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == PHASE_ITEMS / 2)
                begin
                    start <= 1'b0;
                    drain();
                end
                random_request();
            end
            start <= 1'b0;
            drain();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0 && bytes_pending == 0)
            $display("char_lcd_nibble_sequencer test passed");
        else
            $display("char_lcd_nibble_sequencer test failed");
        $finish;
    end

endmodule
